[hw/rtl/spatial_temporal_denoise_core_defines.svh]
// assertion macros shared by the denoise core rtl
// no dependencies; taken in by the files that carry assertions
`ifndef SPATIAL_TEMPORAL_DENOISE_CORE_DEFINES_SVH
`define SPATIAL_TEMPORAL_DENOISE_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define STDN_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define STDN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/stdn_pkg.sv]
// shared types, constants and helper functions for the denoise core
// no dependencies
package stdn_pkg;

	localparam int PIX_W         = 8;
	localparam int COL_W         = 11;
	localparam int IDX_W         = 9;
	localparam int TBL_AW        = IDX_W + 1;
	localparam int TBL_SEL_W     = 2;
	localparam int MAX_WIDTH_DEF = 2048;

	// centre of a coefficient table: index of a zero difference
	localparam logic [IDX_W-1:0] DIFF_BIAS = IDX_W'(256);

	// transaction kinds
	typedef enum logic {
		OP_FILTER = 1'b0,
		OP_LOAD   = 1'b1
	} stdn_op_t;

	// coefficient table codes
	typedef enum logic [TBL_SEL_W-1:0] {
		TBL_LUMA_SPAT   = 2'd0,
		TBL_LUMA_TEMP   = 2'd1,
		TBL_CHROMA_SPAT = 2'd2,
		TBL_CHROMA_TEMP = 2'd3
	} stdn_tbl_t;

	// one coefficient table write
	typedef struct packed {
		logic              en;
		logic              temporal;
		logic [TBL_AW-1:0] addr;
		logic [PIX_W-1:0]  data;
	} stdn_tbl_wr_t;

	// table index for neighbour a against current value b
	function automatic logic [IDX_W-1:0] lp_index(input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b);
		return DIFF_BIAS + {1'b0, a} - {1'b0, b};
	endfunction

	// apply a coefficient byte as a correction modulo 256
	function automatic logic [PIX_W-1:0] lp_apply(input logic [PIX_W-1:0] b,
		input logic [PIX_W-1:0] coef);
		return b + coef;
	endfunction

endpackage

[hw/rtl/stdn_coef_mem.sv]
// coefficient tables: spatial store with two read ports, temporal store with one
// depends on stdn_pkg
module stdn_coef_mem (
	input  logic                         clk,
	input  logic                         en,
	input  stdn_pkg::stdn_tbl_wr_t       wr,
	input  logic [stdn_pkg::TBL_AW-1:0]  h_addr,
	input  logic [stdn_pkg::TBL_AW-1:0]  v_addr,
	input  logic [stdn_pkg::TBL_AW-1:0]  t_addr,
	output logic [stdn_pkg::PIX_W-1:0]   h_data,
	output logic [stdn_pkg::PIX_W-1:0]   v_data,
	output logic [stdn_pkg::PIX_W-1:0]   t_data
);
	import stdn_pkg::*;

	localparam int DEPTH = 1 << TBL_AW;

	logic [PIX_W-1:0] spat_mem [DEPTH];
	logic [PIX_W-1:0] temp_mem [DEPTH];

	// spatial tables: load port, horizontal and vertical read ports
	always_ff @(posedge clk) begin
		if (en) begin
			if (wr.en && !wr.temporal) begin
				spat_mem[wr.addr] <= wr.data;
			end
			h_data <= spat_mem[h_addr];
			v_data <= spat_mem[v_addr];
		end
	end

	// temporal tables: load port and one read port
	always_ff @(posedge clk) begin
		if (en) begin
			if (wr.en && wr.temporal) begin
				temp_mem[wr.addr] <= wr.data;
			end
			t_data <= temp_mem[t_addr];
		end
	end

endmodule

[hw/rtl/stdn_line_store.sv]
// line store of vertically filtered values with write-to-read forwarding
// depends on stdn_pkg
module stdn_line_store #(
	parameter int MAX_WIDTH = stdn_pkg::MAX_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic [$clog2(MAX_WIDTH)-1:0] rd_pos,
	input  logic                       wr_en,
	input  logic [$clog2(MAX_WIDTH)-1:0] wr_pos,
	input  logic [stdn_pkg::PIX_W-1:0] wr_data,
	output logic [stdn_pkg::PIX_W-1:0] rd_data
);
	import stdn_pkg::*;

	localparam int POS_W = $clog2(MAX_WIDTH);

	logic [PIX_W-1:0] line_mem [MAX_WIDTH];
	logic [PIX_W-1:0] rdata_q;
	logic [POS_W-1:0] rd_pos_q;
	logic             fwd_hit_q;
	logic [PIX_W-1:0] fwd_val_q;

	// one write and one registered read per advance
	always_ff @(posedge clk) begin
		if (en) begin
			if (wr_en) begin
				line_mem[wr_pos] <= wr_data;
			end
			rdata_q   <= line_mem[rd_pos];
			rd_pos_q  <= rd_pos;
			fwd_val_q <= wr_data;
		end
	end

	// a write landing on the same edge as the read is caught here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q <= 1'b0;
		end else if (en) begin
			fwd_hit_q <= wr_en && (wr_pos == rd_pos);
		end
	end

	// newest value wins: live write, then captured write, then memory
	always_comb begin
		if (wr_en && (wr_pos == rd_pos_q)) begin
			rd_data = wr_data;
		end else if (fwd_hit_q) begin
			rd_data = fwd_val_q;
		end else begin
			rd_data = rdata_q;
		end
	end

endmodule

[hw/rtl/spatial_temporal_denoise_core.sv]
// accepted pixel transactions pass through the stage registers; results are offered from stage 4
// throughput: one pixel per cycle; the horizontal recursion closes each cycle through the
// spatial table read and one add; a table load waits until earlier pixels have finished
// their vertical lookup, and a waiting result holds the whole pipeline
// reset clears the stage valid bits and the left-neighbour value; tables and line store
// are not cleared and hold undefined data until written (stdn_pkg, memories, defines)
`include "spatial_temporal_denoise_core_defines.svh"

module spatial_temporal_denoise_core #(
	parameter int MAX_WIDTH = stdn_pkg::MAX_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           operation,
	input  logic                           chroma_plane,
	input  logic                           first_row,
	input  logic [stdn_pkg::COL_W-1:0]     column,
	input  logic [stdn_pkg::PIX_W-1:0]     pixel,
	input  logic [stdn_pkg::PIX_W-1:0]     prev_frame_pixel,
	input  logic [stdn_pkg::TBL_SEL_W-1:0] table_select,
	input  logic [stdn_pkg::IDX_W-1:0]     entry_index,
	input  logic [stdn_pkg::PIX_W-1:0]     entry_value,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [stdn_pkg::PIX_W-1:0]     filtered_pixel
);
	import stdn_pkg::*;

	localparam int POS_W    = $clog2(MAX_WIDTH);
	localparam int RECIP_SH = 22;
	localparam int PROD_W   = COL_W + RECIP_SH;
	localparam int MOD_W    = ((POS_W > COL_W) ? POS_W : COL_W) + 1;
	localparam int QM_W     = COL_W + MOD_W;
	localparam logic [RECIP_SH-1:0] RECIP = RECIP_SH'((64'd1 << RECIP_SH) / MAX_WIDTH);

	// handshake and stage control
	logic adv;
	logic load_hold;
	logic accept;
	logic is_filter;
	logic valid_s1, valid_s2, valid_s3, valid_s4;

	// stage 1 payload
	logic             chroma_s1, first_row_s1, col0_s1;
	logic [PIX_W-1:0] pixel_s1, prev_s1;
	logic [COL_W-1:0] col_s1, quot_s1;
	// stage 2 payload
	logic             chroma_s2, first_row_s2;
	logic [PIX_W-1:0] h_s2, prev_s2;
	logic [POS_W-1:0] pos_s2;
	// stage 3 payload
	logic             chroma_s3, first_row_s3;
	logic [PIX_W-1:0] h_s3, prev_s3;
	logic [POS_W-1:0] pos_s3;
	// stage 4 payload
	logic [PIX_W-1:0] v_s4;

	logic [PIX_W-1:0] left_q;

	logic [PIX_W-1:0]  left_fwd;
	logic [PROD_W-1:0] quot_prod;
	logic [PIX_W-1:0]  h_calc, v_calc, line_fwd;
	logic [QM_W-1:0]   qm_full;
	logic [MOD_W-1:0]  rem_raw, rem_fix;
	logic [POS_W-1:0]  pos_calc;
	logic [TBL_AW-1:0] h_addr, v_addr, t_addr;
	logic [PIX_W-1:0]  h_data, v_data, t_data;
	stdn_tbl_wr_t      tbl_wr;

	// pipeline advances unless a result waits untaken
	assign adv       = !valid_s4 || out_ready;
	// a table load waits until earlier pixels are past their vertical lookup
	assign load_hold = (stdn_op_t'(operation) == OP_LOAD) && (valid_s1 || valid_s2);
	assign in_ready  = adv && !load_hold;
	assign accept    = in_valid && in_ready;
	assign is_filter = accept && (stdn_op_t'(operation) == OP_FILTER);

	// table load decode
	always_comb begin
		tbl_wr.en   = accept && (stdn_op_t'(operation) == OP_LOAD);
		tbl_wr.data = entry_value;
		case (stdn_tbl_t'(table_select))
			TBL_LUMA_SPAT: begin
				tbl_wr.temporal = 1'b0;
				tbl_wr.addr     = {1'b0, entry_index};
			end
			TBL_LUMA_TEMP: begin
				tbl_wr.temporal = 1'b1;
				tbl_wr.addr     = {1'b0, entry_index};
			end
			TBL_CHROMA_SPAT: begin
				tbl_wr.temporal = 1'b0;
				tbl_wr.addr     = {1'b1, entry_index};
			end
			TBL_CHROMA_TEMP: begin
				tbl_wr.temporal = 1'b1;
				tbl_wr.addr     = {1'b1, entry_index};
			end
			default: begin
				tbl_wr.temporal = 1'b0;
				tbl_wr.addr     = {1'b0, entry_index};
			end
		endcase
	end

	// horizontal lookup address, left value forwarded from stage 1
	assign left_fwd  = valid_s1 ? h_calc : left_q;
	assign h_addr    = {chroma_plane, lp_index(left_fwd, pixel)};
	// column quotient estimate by reciprocal
	assign quot_prod = PROD_W'(column) * PROD_W'(RECIP);

	// stage 1: horizontal result and line position
	assign h_calc   = col0_s1 ? pixel_s1 : lp_apply(pixel_s1, h_data);
	assign qm_full  = QM_W'(quot_s1) * QM_W'(MAX_WIDTH);
	assign rem_raw  = MOD_W'(col_s1) - qm_full[MOD_W-1:0];
	assign rem_fix  = (rem_raw >= MOD_W'(MAX_WIDTH)) ? rem_raw - MOD_W'(MAX_WIDTH) : rem_raw;
	assign pos_calc = rem_fix[POS_W-1:0];

	// stage 2: vertical lookup address from forwarded line value
	assign v_addr = {chroma_s2, lp_index(line_fwd, h_s2)};

	// stage 3: vertical result and temporal lookup address
	assign v_calc = first_row_s3 ? h_s3 : lp_apply(h_s3, v_data);
	assign t_addr = {chroma_s3, lp_index(prev_s3, v_calc)};

	// stage 4: temporal result
	assign out_valid      = valid_s4;
	assign filtered_pixel = lp_apply(v_s4, t_data);

	// stage valid bits and left neighbour
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			left_q   <= '0;
		end else if (adv) begin
			valid_s1 <= is_filter;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			if (valid_s1) begin
				left_q <= h_calc;
			end
		end
	end

	// payload pipeline
	always_ff @(posedge clk) begin
		if (adv) begin
			chroma_s1    <= chroma_plane;
			first_row_s1 <= first_row;
			col0_s1      <= (column == '0);
			pixel_s1     <= pixel;
			prev_s1      <= prev_frame_pixel;
			col_s1       <= column;
			quot_s1      <= quot_prod[PROD_W-1:RECIP_SH];

			chroma_s2    <= chroma_s1;
			first_row_s2 <= first_row_s1;
			h_s2         <= h_calc;
			prev_s2      <= prev_s1;
			pos_s2       <= pos_calc;

			chroma_s3    <= chroma_s2;
			first_row_s3 <= first_row_s2;
			h_s3         <= h_s2;
			prev_s3      <= prev_s2;
			pos_s3       <= pos_s2;

			v_s4         <= v_calc;
		end
	end

	// coefficient tables
	stdn_coef_mem u_coef_mem (
		.clk    (clk),
		.en     (adv),
		.wr     (tbl_wr),
		.h_addr (h_addr),
		.v_addr (v_addr),
		.t_addr (t_addr),
		.h_data (h_data),
		.v_data (v_data),
		.t_data (t_data)
	);

	// line store, read in stage 1 and written in stage 3
	stdn_line_store #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_line_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.rd_pos  (pos_calc),
		.wr_en   (valid_s3),
		.wr_pos  (pos_s3),
		.wr_data (v_calc),
		.rd_data (line_fwd)
	);

	// checks on recursion, forwarding, load ordering and stall behaviour
	`STDN_ASSERT_NEXT(a_left_follows_h, clk, arst_n, adv && valid_s1, left_q == $past(h_calc), "left value lost horizontal result")
	`STDN_ASSERT_NOW(a_line_forward, clk, arst_n, valid_s2 && valid_s3 && (pos_s2 == pos_s3), line_fwd == v_calc, "line store forwarding missed")
	`STDN_ASSERT_NEXT(a_load_no_result, clk, arst_n, in_valid && in_ready && (stdn_op_t'(operation) == OP_LOAD), !valid_s1, "table load entered pixel pipeline")
	`STDN_ASSERT_NOW(a_load_ordered, clk, arst_n, tbl_wr.en, !valid_s1 && !valid_s2, "table load overtook an earlier pixel")
	`STDN_ASSERT_NEXT(a_stall_freeze, clk, arst_n, !adv, $stable(valid_s2) && $stable(valid_s3) && $stable(v_s4), "pipeline moved during stall")

endmodule

[dv/spatial_temporal_denoise_core_test.sv]
// testbench for spatial_temporal_denoise_core: drives pixel and coefficient-write transactions
// and checks every filtered pixel in order against a prediction kept in the bench
// depends on stdn_pkg and the spatial_temporal_denoise_core rtl
module spatial_temporal_denoise_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import stdn_pkg::*;

	localparam int CLK_HALF      = 2;
	localparam int LINE_LEN      = MAX_WIDTH_DEF;
	localparam int NUM_TABLES    = 4;
	localparam int TABLE_LEN     = 512;
	localparam int MAX_REPORTS   = 10;
	localparam int HOLD_LEN      = 64;
	localparam int SETTLE_CYCLES = 16;
	localparam int TIMEOUT_NS    = 2_000_000;

	// one input transaction, every field carried whatever the operation
	typedef struct {
		stdn_op_t         op;
		logic             chroma;
		logic             top;
		logic [COL_W-1:0] col;
		logic [PIX_W-1:0] pix;
		logic [PIX_W-1:0] prev;
		stdn_tbl_t        tsel;
		logic [IDX_W-1:0] idx;
		logic [PIX_W-1:0] val;
	} denoise_txn_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic                 operation;
	logic                 chroma_plane;
	logic                 first_row;
	logic [COL_W-1:0]     column;
	logic [PIX_W-1:0]     pixel;
	logic [PIX_W-1:0]     prev_frame_pixel;
	logic [TBL_SEL_W-1:0] table_select;
	logic [IDX_W-1:0]     entry_index;
	logic [PIX_W-1:0]     entry_value;
	logic                 out_valid;
	logic                 out_ready;
	logic [PIX_W-1:0]     filtered_pixel;

	// predicted state of the filter
	logic [PIX_W-1:0] coef_mem [NUM_TABLES][TABLE_LEN];
	logic [PIX_W-1:0] row_mem [LINE_LEN];
	bit               row_written [LINE_LEN];
	logic [PIX_W-1:0] left_pix;
	logic [PIX_W-1:0] expected_pixels [$];

	// run control and tallies
	bit send_idle;
	bit recv_idle;
	bit hold_request;
	int pixel_count;
	int load_count;
	int checked_count;
	int fail_count;
	int stall_cycles;

	spatial_temporal_denoise_core DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.operation        (operation),
		.chroma_plane     (chroma_plane),
		.first_row        (first_row),
		.column           (column),
		.pixel            (pixel),
		.prev_frame_pixel (prev_frame_pixel),
		.table_select     (table_select),
		.entry_index      (entry_index),
		.entry_value      (entry_value),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.filtered_pixel   (filtered_pixel)
	);

	// clock
	always begin
		#(CLK_HALF) clk = 1'b1;
		#(CLK_HALF) clk = 1'b0;
	end

	// one low-pass step: neighbour nbr pulls the current value cur through table tbl
	function automatic logic [PIX_W-1:0] smooth_step(input int tbl, input logic [PIX_W-1:0] nbr,
		input logic [PIX_W-1:0] cur);
		logic [IDX_W-1:0] slot;
		slot = IDX_W'(TABLE_LEN / 2) + IDX_W'(nbr) - IDX_W'(cur);
		return cur + coef_mem[tbl][slot];
	endfunction

	// update the predicted state for one transaction; returns 1 when a pixel comes out
	function automatic bit denoise_predict(input denoise_txn_t t, output logic [PIX_W-1:0] res);
		int               spat;
		int               temp;
		logic [PIX_W-1:0] horiz;
		logic [PIX_W-1:0] vert;
		res = '0;
		if (t.op == OP_LOAD) begin
			coef_mem[int'(t.tsel)][t.idx] = t.val;
			return 1'b0;
		end
		spat = t.chroma ? int'(TBL_CHROMA_SPAT) : int'(TBL_LUMA_SPAT);
		temp = t.chroma ? int'(TBL_CHROMA_TEMP) : int'(TBL_LUMA_TEMP);
		// column zero has no left neighbour
		horiz = (t.col == '0) ? t.pix : smooth_step(spat, left_pix, t.pix);
		left_pix = horiz;
		// top row has no row above; the column is always inside the line store
		vert = t.top ? horiz : smooth_step(spat, row_mem[t.col], horiz);
		row_mem[t.col] = vert;
		row_written[t.col] = 1'b1;
		res = smooth_step(temp, t.prev, vert);
		return 1'b1;
	endfunction

	// transaction with every field random
	function automatic denoise_txn_t noise_txn();
		denoise_txn_t t;
		t.op     = stdn_op_t'($urandom_range(0, 1));
		t.chroma = 1'($urandom_range(0, 1));
		t.top    = 1'($urandom_range(0, 1));
		t.col    = COL_W'($urandom_range(0, LINE_LEN - 1));
		t.pix    = PIX_W'($urandom_range(0, 255));
		t.prev   = PIX_W'($urandom_range(0, 255));
		t.tsel   = stdn_tbl_t'($urandom_range(0, NUM_TABLES - 1));
		t.idx    = IDX_W'($urandom_range(0, TABLE_LEN - 1));
		t.val    = PIX_W'($urandom_range(0, 255));
		return t;
	endfunction

	function automatic denoise_txn_t pixel_txn(input logic plane, input logic top, input int col,
		input logic [PIX_W-1:0] pix, input logic [PIX_W-1:0] prev);
		denoise_txn_t t;
		t        = noise_txn();
		t.op     = OP_FILTER;
		t.chroma = plane;
		t.top    = top;
		t.col    = COL_W'(col);
		t.pix    = pix;
		t.prev   = prev;
		return t;
	endfunction

	function automatic denoise_txn_t load_txn(input stdn_tbl_t sel, input int idx,
		input logic [PIX_W-1:0] val);
		denoise_txn_t t;
		t      = noise_txn();
		t.op   = OP_LOAD;
		t.tsel = sel;
		t.idx  = IDX_W'(idx);
		t.val  = val;
		return t;
	endfunction

	function automatic denoise_txn_t random_load();
		return load_txn(stdn_tbl_t'($urandom_range(0, NUM_TABLES - 1)),
			int'($urandom_range(0, TABLE_LEN - 1)), PIX_W'($urandom_range(0, 255)));
	endfunction

	// count and, for the first few, report a failed check
	function automatic void note_failure(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("[%0t] check failed: %s", $time, msg);
	endfunction

	// offer one transaction, wait for the handshake and record the expected pixel
	task automatic send_txn(input denoise_txn_t t, output logic [PIX_W-1:0] res);
		int gap;
		bit has_res;
		gap = 0;
		if (send_idle && $urandom_range(0, 5) == 0)
			gap = int'($urandom_range(1, 4));
		repeat (gap) @(negedge clk);
		operation        = t.op;
		chroma_plane     = t.chroma;
		first_row        = t.top;
		column           = t.col;
		pixel            = t.pix;
		prev_frame_pixel = t.prev;
		table_select     = t.tsel;
		entry_index      = t.idx;
		entry_value      = t.val;
		in_valid         = 1'b1;
		@(posedge clk);
		while (!in_ready) begin
			stall_cycles++;
			@(posedge clk);
		end
		has_res = denoise_predict(t, res);
		if (has_res) begin
			expected_pixels.push_back(res);
			pixel_count++;
		end else begin
			load_count++;
		end
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// raster frames of small planes, each frame fed the previous frame's filtered output
	task automatic stream_frames(input int n_pixels);
		logic [PIX_W-1:0] prev_img [8][32];
		logic [PIX_W-1:0] res;
		logic             plane;
		int               sent;
		int               w;
		int               h;
		int               n_frames;
		int               shade;
		sent = 0;
		while (sent < n_pixels) begin
			plane    = 1'($urandom_range(0, 1));
			w        = int'($urandom_range(2, 24));
			h        = int'($urandom_range(2, 6));
			n_frames = int'($urandom_range(2, 3));
			shade    = int'($urandom_range(0, 255));
			for (int f = 0; f < n_frames; f++) begin
				for (int r = 0; r < h; r++) begin
					for (int c = 0; c < w; c++) begin
						// occasional coefficient rewrite in the middle of a frame
						if ($urandom_range(0, 39) == 0)
							send_txn(random_load(), res);
						if (f == 0)
							prev_img[r][c] = PIX_W'($urandom_range(0, 255));
						send_txn(pixel_txn(plane, r == 0, c,
							PIX_W'(shade + 4 * c + 3 * r + int'($urandom_range(0, 24))),
							prev_img[r][c]), res);
						prev_img[r][c] = res;
						sent++;
					end
				end
			end
		end
	endtask

	// fill all four tables with a pull towards the neighbour of random strength
	task automatic test_table_fill();
		logic [PIX_W-1:0] res;
		int               weight;
		for (int sel = 0; sel < NUM_TABLES; sel++) begin
			weight = int'($urandom_range(2, 14));
			for (int i = 0; i < TABLE_LEN; i++)
				send_txn(load_txn(stdn_tbl_t'(sel), i,
					PIX_W'(((i - TABLE_LEN / 2) * weight) / 16)), res);
		end
	endtask

	// extremes, top row, column zero, last column, write just before use
	task automatic test_edges();
		logic [PIX_W-1:0] res;
		send_txn(load_txn(TBL_LUMA_SPAT, 0, 8'hFF), res);
		send_txn(load_txn(TBL_CHROMA_TEMP, TABLE_LEN - 1, 8'h00), res);
		send_txn(load_txn(TBL_LUMA_TEMP, TABLE_LEN - 1, 8'hFF), res);
		send_txn(pixel_txn(1'b0, 1'b1, 0, 8'h00, 8'hFF), res);
		send_txn(pixel_txn(1'b0, 1'b1, 1, 8'hFF, 8'h00), res);
		send_txn(pixel_txn(1'b0, 1'b1, 2, 8'hFF, 8'hFF), res);
		send_txn(pixel_txn(1'b0, 1'b1, 3, 8'h00, 8'h00), res);
		send_txn(pixel_txn(1'b0, 1'b0, 0, 8'hFF, 8'h00), res);
		send_txn(pixel_txn(1'b0, 1'b0, 1, 8'h00, 8'hFF), res);
		send_txn(load_txn(TBL_LUMA_SPAT, TABLE_LEN / 2, 8'h07), res);
		send_txn(pixel_txn(1'b0, 1'b0, 2, 8'h80, 8'h7F), res);
		send_txn(pixel_txn(1'b0, 1'b0, 3, 8'h7F, 8'h80), res);
		send_txn(pixel_txn(1'b1, 1'b1, LINE_LEN - 1, 8'hFF, 8'h00), res);
		send_txn(pixel_txn(1'b1, 1'b0, LINE_LEN - 1, 8'h00, 8'hFF), res);
		send_txn(pixel_txn(1'b1, 1'b1, LINE_LEN / 2, 8'h55, 8'hAA), res);
		send_txn(pixel_txn(1'b1, 1'b0, 0, 8'h00, 8'h00), res);
		send_txn(load_txn(TBL_CHROMA_SPAT, 1, 8'h80), res);
		send_txn(pixel_txn(1'b1, 1'b0, 1, 8'hFF, 8'hFF), res);
	endtask

	// well-formed rasters with random content and idling on both sides
	task automatic test_raster_frames();
		stream_frames(400);
	endtask

	// scattered columns, plane switches and table writes between pixels
	task automatic test_random_mix();
		denoise_txn_t     t;
		logic [PIX_W-1:0] res;
		for (int n = 0; n < 250; n++) begin
			t = noise_txn();
			if ($urandom_range(0, 6) != 0) begin
				t.op = OP_FILTER;
				if ($urandom_range(0, 1) == 0)
					t.col = COL_W'($urandom_range(0, 31));
				// never read a line store entry that has not been written
				if (!row_written[t.col])
					t.top = 1'b1;
			end else begin
				t.op = OP_LOAD;
			end
			send_txn(t, res);
		end
	endtask

	// long output hold-off while input keeps coming, so the pipeline fills
	task automatic test_backpressure();
		send_idle    = 1'b0;
		hold_request = 1'b1;
		stream_frames(80);
		send_idle    = 1'b1;
	endtask

	// closing stretch at full rate with no idling anywhere
	task automatic test_steady_stream();
		send_idle = 1'b0;
		recv_idle = 1'b0;
		stream_frames(120);
	endtask

	// receiver: random stall bursts plus the long hold-off on request
	initial begin
		int stall_left;
		stall_left = 0;
		out_ready  = 1'b1;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left   = HOLD_LEN;
			end
			if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else if (recv_idle && $urandom_range(0, 5) == 0) begin
				out_ready  = 1'b0;
				stall_left = int'($urandom_range(0, 3));
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// result check against the oldest expected pixel
	always @(posedge clk) begin
		logic [PIX_W-1:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_pixels.size() == 0) begin
				note_failure($sformatf("unexpected result %0d", filtered_pixel));
			end else begin
				want = expected_pixels.pop_front();
				checked_count++;
				if (filtered_pixel !== want)
					note_failure($sformatf("filtered_pixel expected %0d got %0d",
						want, filtered_pixel));
			end
		end
	end

	// run limit
	initial begin
		#(TIMEOUT_NS);
		$display("FAILURE");
		$finish;
	end

	// main sequence
	initial begin
		arst_n           = 1'b0;
		in_valid         = 1'b0;
		operation        = OP_FILTER;
		chroma_plane     = 1'b0;
		first_row        = 1'b0;
		column           = '0;
		pixel            = '0;
		prev_frame_pixel = '0;
		table_select     = TBL_LUMA_SPAT;
		entry_index      = '0;
		entry_value      = '0;
		left_pix         = '0;
		send_idle        = 1'b1;
		recv_idle        = 1'b1;
		hold_request     = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_table_fill();
		test_edges();
		test_raster_frames();
		test_random_mix();
		test_backpressure();
		test_steady_stream();

		// drain, then allow for anything stray
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d pixels and %0d coefficient writes sent, %0d results checked",
			pixel_count, load_count, checked_count);
		$display("input held off for %0d cycles; %0d failed checks",
			stall_cycles, fail_count);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
